[rtl/ssc_pkg.sv]
// Shared types and constants for the subset sum counter.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int VAL_W        = 30;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SUB_W        = MAX_ELEMENTS + 1;
    localparam int SUM_W        = VAL_W + IDX_W;
    localparam int COUNT_W      = 17;
    localparam int IN_DATA_W    = ((VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((COUNT_W + 7) / 8) * 8;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_STORE_COUNT,
        CMD_COUNT
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  slot;
        logic [CNT_W-1:0]  n;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } st_t;

    function automatic logic [IDX_W-1:0] lowest_bit(input logic [MAX_ELEMENTS-1:0] v);
        logic [IDX_W-1:0] pos;
        pos = '0;
        for (int i = MAX_ELEMENTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = IDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

[rtl/ssc_front.sv]
// Front end: accepts words, tracks the fill level and tags each word with a command.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [ssc_pkg::VAL_W-1:0]    value,
    input  wire logic                         last,
    output ssc_pkg::entry_t                   push_entry,
    output logic                              push
);

    logic [ssc_pkg::CNT_W-1:0] cnt_reg;
    logic [ssc_pkg::CNT_W-1:0] cnt_next;
    logic                      keep;

    always_comb
    begin
        keep             = (cnt_reg < ssc_pkg::CNT_W'(ssc_pkg::MAX_ELEMENTS));
        push_entry.value = value;
        push_entry.slot  = cnt_reg[ssc_pkg::IDX_W-1:0];
        push_entry.n     = keep ? cnt_reg + 1'b1 : cnt_reg;
        if (last)
        begin
            push_entry.cmd = keep ? ssc_pkg::CMD_STORE_COUNT : ssc_pkg::CMD_COUNT;
        end
        else
        begin
            push_entry.cmd = ssc_pkg::CMD_STORE;
        end
        // drop a plain word once the store is full
        push     = accept && (keep || last);
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (last)
            begin
                cnt_next = '0;
            end
            else if (keep)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ssc_queue.sv]
// Short command queue between the front end and the counting engine.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ssc_pkg::entry_t  push_entry,
    input  wire logic             pop,
    output ssc_pkg::entry_t       head,
    output ssc_pkg::q_stat_t      stat
);

    ssc_pkg::entry_t           mem [ssc_pkg::Q_DEPTH];
    logic [ssc_pkg::Q_AW-1:0]  wr_ptr_reg;
    logic [ssc_pkg::Q_AW-1:0]  wr_ptr_next;
    logic [ssc_pkg::Q_AW-1:0]  rd_ptr_reg;
    logic [ssc_pkg::Q_AW-1:0]  rd_ptr_next;
    logic [ssc_pkg::Q_AW:0]    level_reg;
    logic [ssc_pkg::Q_AW:0]    level_next;
    logic                      do_push;
    logic                      do_pop;

    always_comb
    begin
        stat.full   = (level_reg == (ssc_pkg::Q_AW + 1)'(ssc_pkg::Q_DEPTH));
        stat.empty  = (level_reg == '0);
        head        = mem[rd_ptr_reg];
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ssc_back.sv]
// Counting engine: holds the element store and walks all subsets in Gray-code order.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ssc_pkg::entry_t               head,
    input  wire ssc_pkg::q_stat_t              q_stat,
    input  wire logic [ssc_pkg::VAL_W-1:0]     target,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [ssc_pkg::COUNT_W-1:0]        out_count,
    output ssc_pkg::back_stat_t                stat
);

    logic [ssc_pkg::VAL_W-1:0]        store [ssc_pkg::MAX_ELEMENTS];

    ssc_pkg::st_t                     state_reg;
    ssc_pkg::st_t                     state_next;
    logic [ssc_pkg::CNT_W-1:0]        n_reg;
    logic [ssc_pkg::CNT_W-1:0]        n_next;
    logic [ssc_pkg::SUB_W-1:0]        i_reg;
    logic [ssc_pkg::SUB_W-1:0]        i_next;
    logic [ssc_pkg::MAX_ELEMENTS-1:0] chosen_reg;
    logic [ssc_pkg::MAX_ELEMENTS-1:0] chosen_next;
    logic                             p1_valid_reg;
    logic                             p1_valid_next;
    logic                             sub1_reg;
    logic                             sub1_next;
    logic [ssc_pkg::VAL_W-1:0]        v1_reg;
    logic                             p2_valid_reg;
    logic                             p2_valid_next;
    logic [ssc_pkg::SUM_W-1:0]        sum_reg;
    logic [ssc_pkg::SUM_W-1:0]        sum_next;
    logic [ssc_pkg::COUNT_W-1:0]      hits_reg;
    logic [ssc_pkg::COUNT_W-1:0]      hits_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [ssc_pkg::COUNT_W-1:0]      out_count_reg;
    logic [ssc_pkg::COUNT_W-1:0]      out_count_next;

    logic [ssc_pkg::SUB_W-1:0]        total;
    logic [ssc_pkg::IDX_W-1:0]        b;
    logic                             issue;
    logic                             pop;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        chosen_next    = chosen_reg;
        sub1_next      = sub1_reg;
        sum_next       = sum_reg;
        hits_next      = hits_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pop            = 1'b0;
        issue          = 1'b0;
        total          = ssc_pkg::SUB_W'(1) << n_reg;
        b              = ssc_pkg::lowest_bit(i_reg[ssc_pkg::MAX_ELEMENTS-1:0]);

        case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (head.cmd != ssc_pkg::CMD_STORE)
                    begin
                        n_next      = head.n;
                        i_next      = ssc_pkg::SUB_W'(1);
                        chosen_next = '0;
                        sum_next    = '0;
                        hits_next   = (target == '0) ? ssc_pkg::COUNT_W'(1) : '0;
                        state_next  = ssc_pkg::ST_RUN;
                    end
                end
            end
            ssc_pkg::ST_RUN:
            begin
                issue = (i_reg < total);
                if (!issue && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ssc_pkg::ST_DONE;
                end
            end
            ssc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = hits_reg;
                    state_next     = ssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase

        // stage 1: pick the element that flips
        p1_valid_next = issue;
        if (issue)
        begin
            sub1_next      = chosen_reg[b];
            chosen_next[b] = ~chosen_reg[b];
            i_next         = i_reg + 1'b1;
        end

        // stage 2: update the running sum
        p2_valid_next = p1_valid_reg;
        if (p1_valid_reg)
        begin
            if (sub1_reg)
            begin
                sum_next = sum_reg - ssc_pkg::SUM_W'(v1_reg);
            end
            else
            begin
                sum_next = sum_reg + ssc_pkg::SUM_W'(v1_reg);
            end
        end

        // stage 3: compare and count
        if (p2_valid_reg && (sum_reg == ssc_pkg::SUM_W'(target)) &&
            (hits_reg != ssc_pkg::COUNT_MAX))
        begin
            hits_next = hits_reg + 1'b1;
        end

        stat.busy = (state_reg != ssc_pkg::ST_IDLE);
        stat.pop  = pop;
        out_valid = out_valid_reg;
        out_count = out_count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop && (head.cmd != ssc_pkg::CMD_COUNT))
        begin
            store[head.slot] <= head.value;
        end
        if (issue)
        begin
            v1_reg <= store[b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssc_pkg::ST_IDLE;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        i_reg         <= i_next;
        chosen_reg    <= chosen_next;
        sub1_reg      <= sub1_next;
        sum_reg       <= sum_next;
        hits_reg      <= hits_next;
        out_count_reg <= out_count_next;
    end

endmodule

`default_nettype wire

[rtl/subset_sum_counter.sv]
// Subset sum counter: a word without tlast passes through the queue into the store.
// A word with tlast closes a set of n elements and counts its subsets; the engine tests
// one subset per cycle through a three-stage add/compare pipeline.
// Up to four words queue up while the engine counts; the result waits in an output register.
// Reset (rst_n low, asynchronous) empties the queue and the store and clears target_sum.
// Depends on ssc_pkg, ssc_front, ssc_queue and ssc_back.
`timescale 1ns / 1ps
`default_nettype none

module subset_sum_counter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ssc_pkg::IN_DATA_W-1:0]     s_tdata,   // element_value
    input  wire logic                              s_tlast,   // last_element
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ssc_pkg::OUT_DATA_W-1:0]         m_tdata,   // subset_count
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ssc_pkg::VAL_W-1:0]         cfg_data   // target_sum
);

    logic [ssc_pkg::VAL_W-1:0]   target_reg;
    logic [ssc_pkg::COUNT_W-1:0] count;
    logic                        accept;
    logic                        push;
    ssc_pkg::entry_t             push_entry;
    ssc_pkg::entry_t             head;
    ssc_pkg::q_stat_t            q_stat;
    ssc_pkg::back_stat_t         back_stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;
    assign m_tdata   = ssc_pkg::OUT_DATA_W'(count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    ssc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .value      (s_tdata[ssc_pkg::VAL_W-1:0]),
        .last       (s_tlast),
        .push_entry (push_entry),
        .push       (push)
    );

    ssc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (back_stat.pop),
        .head       (head),
        .stat       (q_stat)
    );

    ssc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .target    (target_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_count (count),
        .stat      (back_stat)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !back_stat.pop)
        else $error("pop from empty queue");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.busy |-> !back_stat.pop)
        else $error("queue popped while counting");

    a_result_from_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(back_stat.busy))
        else $error("result without a count");

endmodule

`default_nettype wire

[tb/tb_subset_sum_counter.sv]
// Self-checking testbench for subset_sum_counter: directed sets, then random sets per target.
// Predicts each subset count from its own copy of the store; depends on ssc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_subset_sum_counter;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam logic [ssc_pkg::VAL_W-1:0] VAL_TOP = 30'd1000000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ssc_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ssc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ssc_pkg::VAL_W-1:0] cfg_data = '0;

    logic [ssc_pkg::VAL_W-1:0] held_values [ssc_pkg::MAX_ELEMENTS];
    int unsigned held_n = 0;
    logic [ssc_pkg::VAL_W-1:0] target_model = '0;
    logic [ssc_pkg::COUNT_W-1:0] pending_counts [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    bit src_gaps = 1'b1;
    bit sink_gaps = 1'b1;

    subset_sum_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Walk the held set in Gray-code order with a wide running sum.
    function automatic logic [ssc_pkg::COUNT_W-1:0] count_subsets();
        logic [63:0] running;
        logic [ssc_pkg::MAX_ELEMENTS-1:0] chosen;
        logic [31:0] hits;
        int unsigned b;
        running = '0;
        chosen = '0;
        hits = (target_model == '0) ? 32'd1 : 32'd0;
        for (int unsigned g = 1; g < (32'd1 << held_n); g++)
        begin
            b = 0;
            while (((g >> b) & 1) == 0)
            begin
                b++;
            end
            if (chosen[b])
            begin
                running = running - 64'(held_values[b]);
            end
            else
            begin
                running = running + 64'(held_values[b]);
            end
            chosen[b] = ~chosen[b];
            if (running == {34'd0, target_model})
            begin
                hits++;
            end
        end
        return (hits > ssc_pkg::COUNT_MAX) ? ssc_pkg::COUNT_MAX : hits[ssc_pkg::COUNT_W-1:0];
    endfunction

    task automatic push_element(input logic [ssc_pkg::VAL_W-1:0] value, input logic last);
        if (src_gaps && $urandom_range(3, 0) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ssc_pkg::IN_DATA_W - ssc_pkg::VAL_W){1'b0}}, value};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        // store full: drop the element, but still count on last
        if (held_n < ssc_pkg::MAX_ELEMENTS)
        begin
            held_values[held_n] = value;
            held_n++;
        end
        if (last)
        begin
            pending_counts.push_back(count_subsets());
            held_n = 0;
        end
        @(negedge clk);
    endtask

    task automatic set_target(input logic [ssc_pkg::VAL_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        target_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_set(input int unsigned size);
        logic [ssc_pkg::VAL_W-1:0] vals [20];
        logic [63:0] partial;
        partial = '0;
        for (int unsigned k = 0; k < size; k++)
        begin
            case ($urandom_range(7, 0))
                0: vals[k] = '0;
                1: vals[k] = VAL_TOP;
                2, 3: vals[k] = ssc_pkg::VAL_W'($urandom_range(1000000000, 0));
                default: vals[k] = ssc_pkg::VAL_W'($urandom_range(
                    (target_model < 30'd64) ? 32'd15 : 32'(target_model), 0));
            endcase
            if (k + 1 < size && $urandom_range(1, 0) == 1)
            begin
                partial = partial + 64'(vals[k]);
            end
        end
        // if the partial sum fits, usually close the set so some subset meets the target
        if (partial <= {34'd0, target_model} && $urandom_range(4, 0) != 0)
        begin
            vals[size-1] = target_model - partial[ssc_pkg::VAL_W-1:0];
        end
        for (int unsigned k = 0; k < size; k++)
        begin
            push_element(vals[k], k == size - 1);
        end
    endtask

    task automatic test_reset_target();
        push_element('0, 1'b1);
        push_element(30'd5, 1'b1);
        push_element(30'd7, 1'b0);
        push_element('0, 1'b1);
    endtask

    task automatic test_wide_values();
        set_target(VAL_TOP);
        push_element(VAL_TOP, 1'b1);
        push_element(30'd500000000, 1'b0);
        push_element(30'd500000000, 1'b0);
        push_element(VAL_TOP, 1'b1);
    endtask

    task automatic test_store_full();
        set_target('0);
        repeat (ssc_pkg::MAX_ELEMENTS) push_element('0, 1'b0);
        push_element('0, 1'b1);
    endtask

    task automatic test_random_sets();
        logic [ssc_pkg::VAL_W-1:0] phase_target;
        int unsigned sent;
        int unsigned pick;
        int unsigned size;
        for (int unsigned phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: phase_target = '0;
                1: phase_target = VAL_TOP;
                2: phase_target = ssc_pkg::VAL_W'($urandom_range(40, 1));
                3, 4: phase_target = ssc_pkg::VAL_W'($urandom_range(1000000000, 0));
                default: phase_target = ssc_pkg::VAL_W'($urandom_range(20, 0));
            endcase
            if (phase == 5)
            begin
                src_gaps = 1'b0;
                sink_gaps = 1'b0;
            end
            set_target(phase_target);
            sent = 0;
            while (sent < 16)
            begin
                pick = $urandom_range(24, 0);
                size = (pick == 0) ? 16 : (pick == 1) ? 17 : $urandom_range(7, 1);
                send_random_set(size);
                sent += size;
            end
        end
    endtask

    initial
    begin : sink_stalls
        forever
        begin
            @(negedge clk);
            if (sink_gaps && $urandom_range(4, 0) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(13, 1)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_counts
        logic [ssc_pkg::COUNT_W-1:0] want;
        if (m_tvalid && m_tready)
        begin
            if (pending_counts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected count word: got %0d", m_tdata);
                end
            end
            else
            begin
                want = pending_counts.pop_front();
                if (m_tdata !== ssc_pkg::OUT_DATA_W'(want))
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("subset_count mismatch: expected %0d, got %0d", want, m_tdata);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_target();
        test_wide_values();
        test_store_full();
        test_random_sets();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/ssc_pkg.sv
rtl/ssc_front.sv
rtl/ssc_queue.sv
rtl/ssc_back.sv
rtl/subset_sum_counter.sv
tb/tb_subset_sum_counter.sv
